FILE: src/cmmg_pkg.sv
// Shared types and constants of the community move / modularity gain engine.
// No dependencies; used by every module under src.
`default_nettype none
package cmmg_pkg;
  localparam int MAX_NODES  = 1024;
  localparam int MAX_DEGREE = 32;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int DEG_W      = $clog2(MAX_DEGREE + 1);
  localparam int SLOT_W     = $clog2(MAX_DEGREE);
  localparam int NBR_AW     = NODE_W + SLOT_W;
  localparam int DSUM_W     = 16;
  localparam int EDGE_W     = 15;
  localparam int GAIN_W     = 23;
  localparam int SUM_W      = DSUM_W + DEG_W + 5;

  localparam logic signed [SUM_W-1:0] GAIN_MAX = SUM_W'((64'sd1 <<< (GAIN_W - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] GAIN_MIN = -GAIN_MAX - SUM_W'(1);

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_MOVE  = 2'd1,
    OP_TRY   = 2'd2,
    OP_QUERY = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] partner;
    logic [NODE_W-1:0] target;
  } req_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain;
    logic                     applied;
    logic                     status;
    logic [NODE_W-1:0]        cur;
    logic [DSUM_W-1:0]        cdeg;
    logic [EDGE_W-1:0]        cedges;
  } res_t;

  typedef struct packed {
    logic clearing;
    logic req_pop;
  } eng_stat_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_LOOKUP, S_FIRST, S_PARTNER, S_ADD_SUM_U, S_ADD_RD_V,
    S_ADD_SUM_V, S_ADD_EDGE, S_OLD_SUM, S_NEW_SUM, S_NBR, S_LABEL, S_MUL,
    S_SUM, S_UPD_OLD, S_UPD_NEW, S_UPD_EDGE, S_FIN, S_OUT
  } st_e;
endpackage
`default_nettype wire

FILE: src/cmmg_front.sv
// Front end: two-entry request queue that decodes and wraps incoming requests.
// Depends on cmmg_pkg.
`default_nettype none
module cmmg_front (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push_i,
  input  wire  [1:0]                  operation_i,
  input  wire  [cmmg_pkg::NODE_W-1:0] node_i,
  input  wire  [cmmg_pkg::NODE_W-1:0] partner_node_i,
  input  wire  [cmmg_pkg::NODE_W-1:0] target_community_i,
  output logic                        full_o,
  input  wire  cmmg_pkg::eng_stat_t   stat_i,
  output logic                        req_valid_o,
  output cmmg_pkg::req_t              req_o
);
  cmmg_pkg::req_t ent_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           acc, pop;
  cmmg_pkg::req_t req_in;

  // pack the request fields; the operation code is cast to op_e
  always_comb begin
    req_in.op      = cmmg_pkg::op_e'(operation_i);
    req_in.node    = node_i;
    req_in.partner = partner_node_i;
    req_in.target  = target_community_i;
  end

  assign full_o      = (cnt_q == 2'd2) || stat_i.clearing;
  assign acc         = push_i && !full_o;
  assign req_valid_o = (cnt_q != 2'd0);
  assign pop         = stat_i.req_pop && req_valid_o;
  assign req_o       = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (acc) ent_q[wr_q] <= req_in;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (acc) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: src/cmmg_resq.sv
// Two-entry result queue between the engine and the result ports.
// Depends on cmmg_pkg.
`default_nettype none
module cmmg_resq (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  wire  cmmg_pkg::res_t  res_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output logic                  empty_o,
  output cmmg_pkg::res_t        res_o
);
  cmmg_pkg::res_t ent_q [2];
  logic           wr_q, rd_q;
  logic [1:0]     cnt_q;
  logic           acc, pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign acc     = push_i && !full_o;
  assign pop     = pop_i && !empty_o;
  assign res_o   = ent_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (acc) ent_q[wr_q] <= res_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (acc) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

FILE: src/cmmg_engine.sv
// Back end: sequencer over the label, degree, neighbor and community memories.
// Depends on cmmg_pkg.
`default_nettype none
module cmmg_engine (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        req_valid_i,
  input  wire  cmmg_pkg::req_t       req_i,
  output cmmg_pkg::eng_stat_t        stat_o,
  output logic                       res_push_o,
  output cmmg_pkg::res_t             res_o,
  input  wire                        res_full_i
);
  localparam int NW = cmmg_pkg::NODE_W;
  localparam int DW = cmmg_pkg::DEG_W;
  localparam int SW = cmmg_pkg::SLOT_W;
  localparam int CW = cmmg_pkg::DSUM_W;
  localparam int EW = cmmg_pkg::EDGE_W;
  localparam int XW = cmmg_pkg::SUM_W;

  // memories
  logic [NW-1:0] lab_mem  [cmmg_pkg::MAX_NODES];
  logic [DW-1:0] deg_mem  [cmmg_pkg::MAX_NODES];
  logic [NW-1:0] nbr_mem  [cmmg_pkg::MAX_NODES * cmmg_pkg::MAX_DEGREE];
  logic [CW-1:0] dsum_mem [cmmg_pkg::MAX_NODES];
  logic [EW-1:0] iedg_mem [cmmg_pkg::MAX_NODES];

  logic                      lab_we, deg_we, nbr_we, dsum_we, iedg_we;
  logic [NW-1:0]             lab_wa, lab_ra, deg_wa, deg_ra, dsum_wa, dsum_ra, iedg_wa, iedg_ra;
  logic [cmmg_pkg::NBR_AW-1:0] nbr_wa, nbr_ra;
  logic [NW-1:0]             lab_wd, nbr_wd, lab_rd_q, nbr_rd_q;
  logic [DW-1:0]             deg_wd, deg_rd_q;
  logic [CW-1:0]             dsum_wd, dsum_rd_q;
  logic [EW-1:0]             iedg_wd, iedg_rd_q;

  cmmg_pkg::st_e  st_q, st_d;
  cmmg_pkg::req_t rq_q, rq_d;
  logic [NW-1:0]  clr_q, clr_d, cu_q, cu_d, cv_q, cv_d;
  logic [DW-1:0]  degu_q, degu_d, degv_q, degv_d, ko_q, ko_d, kn_q, kn_d, idx_q, idx_d, nxt;
  logic [CW-1:0]  dold_q, dold_d, dnew_q, dnew_d;
  logic [EW-1:0]  edge_q, edge_d;
  logic signed [XW-1:0] p1_q, p1_d, p2_q, p2_d, sum, m_s, kn_s, ko_s, deg_s, dold_s, dnew_s;
  logic signed [cmmg_pkg::GAIN_W-1:0] gain_q, gain_d;
  logic           app_q, app_d, sts_q, sts_d, apply, reject;

  always_ff @(posedge clk_i) begin
    if (lab_we) lab_mem[lab_wa] <= lab_wd;
    lab_rd_q <= lab_mem[lab_ra];
  end
  always_ff @(posedge clk_i) begin
    if (deg_we) deg_mem[deg_wa] <= deg_wd;
    deg_rd_q <= deg_mem[deg_ra];
  end
  always_ff @(posedge clk_i) begin
    if (nbr_we) nbr_mem[nbr_wa] <= nbr_wd;
    nbr_rd_q <= nbr_mem[nbr_ra];
  end
  always_ff @(posedge clk_i) begin
    if (dsum_we) dsum_mem[dsum_wa] <= dsum_wd;
    dsum_rd_q <= dsum_mem[dsum_ra];
  end
  always_ff @(posedge clk_i) begin
    if (iedg_we) iedg_mem[iedg_wa] <= iedg_wd;
    iedg_rd_q <= iedg_mem[iedg_ra];
  end

  assign nxt    = idx_q + DW'(1);
  assign reject = (rq_q.node == rq_q.partner) ||
                  (degu_q >= DW'(cmmg_pkg::MAX_DEGREE)) ||
                  (deg_rd_q >= DW'(cmmg_pkg::MAX_DEGREE));
  assign m_s    = {{(XW-EW){1'b0}}, edge_q};
  assign kn_s   = {{(XW-DW){1'b0}}, kn_q};
  assign ko_s   = {{(XW-DW){1'b0}}, ko_q};
  assign deg_s  = {{(XW-DW){1'b0}}, degu_q};
  assign dold_s = {{(XW-CW){1'b0}}, dold_q};
  assign dnew_s = {{(XW-CW){1'b0}}, dnew_q};
  assign sum    = (p1_q <<< 1) + p2_q;
  assign apply  = (rq_q.op == cmmg_pkg::OP_MOVE) ||
                  ((rq_q.op == cmmg_pkg::OP_TRY) && (sum > 0));

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      cmmg_pkg::S_CLEAR:     if (&clr_q) st_d = cmmg_pkg::S_IDLE;
      cmmg_pkg::S_IDLE:      if (req_valid_i) st_d = cmmg_pkg::S_LOOKUP;
      cmmg_pkg::S_LOOKUP:    st_d = cmmg_pkg::S_FIRST;
      cmmg_pkg::S_FIRST: begin
        if (rq_q.op == cmmg_pkg::OP_ADD) st_d = cmmg_pkg::S_PARTNER;
        else if (lab_rd_q == rq_q.target) st_d = cmmg_pkg::S_FIN;
        else st_d = cmmg_pkg::S_OLD_SUM;
      end
      cmmg_pkg::S_PARTNER:   st_d = reject ? cmmg_pkg::S_FIN : cmmg_pkg::S_ADD_SUM_U;
      cmmg_pkg::S_ADD_SUM_U: st_d = cmmg_pkg::S_ADD_RD_V;
      cmmg_pkg::S_ADD_RD_V:  st_d = cmmg_pkg::S_ADD_SUM_V;
      cmmg_pkg::S_ADD_SUM_V: st_d = cmmg_pkg::S_ADD_EDGE;
      cmmg_pkg::S_ADD_EDGE:  st_d = cmmg_pkg::S_FIN;
      cmmg_pkg::S_OLD_SUM:   st_d = cmmg_pkg::S_NEW_SUM;
      cmmg_pkg::S_NEW_SUM:   st_d = (degu_q == '0) ? cmmg_pkg::S_MUL : cmmg_pkg::S_NBR;
      cmmg_pkg::S_NBR:       st_d = cmmg_pkg::S_LABEL;
      cmmg_pkg::S_LABEL:     st_d = (nxt < degu_q) ? cmmg_pkg::S_NBR : cmmg_pkg::S_MUL;
      cmmg_pkg::S_MUL:       st_d = cmmg_pkg::S_SUM;
      cmmg_pkg::S_SUM:       st_d = apply ? cmmg_pkg::S_UPD_OLD : cmmg_pkg::S_FIN;
      cmmg_pkg::S_UPD_OLD:   st_d = cmmg_pkg::S_UPD_NEW;
      cmmg_pkg::S_UPD_NEW:   st_d = cmmg_pkg::S_UPD_EDGE;
      cmmg_pkg::S_UPD_EDGE:  st_d = cmmg_pkg::S_FIN;
      cmmg_pkg::S_FIN:       st_d = cmmg_pkg::S_OUT;
      cmmg_pkg::S_OUT:       if (!res_full_i) st_d = cmmg_pkg::S_IDLE;
      default:               st_d = cmmg_pkg::S_IDLE;
    endcase
  end

  // outputs, memory ports, datapath
  always_comb begin
    rq_d = rq_q; clr_d = clr_q; cu_d = cu_q; cv_d = cv_q;
    degu_d = degu_q; degv_d = degv_q; ko_d = ko_q; kn_d = kn_q; idx_d = idx_q;
    dold_d = dold_q; dnew_d = dnew_q; edge_d = edge_q;
    p1_d = p1_q; p2_d = p2_q; gain_d = gain_q; app_d = app_q; sts_d = sts_q;
    lab_we = 1'b0; deg_we = 1'b0; nbr_we = 1'b0; dsum_we = 1'b0; iedg_we = 1'b0;
    lab_wa = rq_q.node; lab_wd = rq_q.target; lab_ra = rq_q.node;
    deg_wa = rq_q.node; deg_wd = degu_q + DW'(1); deg_ra = rq_q.node;
    nbr_wa = {rq_q.node, degu_q[SW-1:0]}; nbr_wd = rq_q.partner;
    nbr_ra = {rq_q.node, idx_q[SW-1:0]};
    dsum_wa = cu_q; dsum_wd = dsum_rd_q + CW'(1); dsum_ra = rq_q.target;
    iedg_wa = cu_q; iedg_wd = iedg_rd_q + EW'(1); iedg_ra = rq_q.target;
    stat_o.clearing = (st_q == cmmg_pkg::S_CLEAR);
    stat_o.req_pop  = 1'b0;
    res_push_o = 1'b0;
    res_o.gain = gain_q; res_o.applied = app_q; res_o.status = sts_q;
    res_o.cur = lab_rd_q; res_o.cdeg = dsum_rd_q; res_o.cedges = iedg_rd_q;
    case (st_q)
      cmmg_pkg::S_CLEAR: begin
        lab_we = 1'b1; deg_we = 1'b1; dsum_we = 1'b1; iedg_we = 1'b1;
        lab_wa = clr_q; deg_wa = clr_q; dsum_wa = clr_q; iedg_wa = clr_q;
        lab_wd = '0; deg_wd = '0; dsum_wd = '0; iedg_wd = '0;
        clr_d = clr_q + NW'(1);
      end
      cmmg_pkg::S_IDLE: begin
        stat_o.req_pop = 1'b1;
        rq_d = req_i; gain_d = '0; app_d = 1'b0; sts_d = 1'b0;
      end
      cmmg_pkg::S_FIRST: begin
        cu_d = lab_rd_q; degu_d = deg_rd_q;
        lab_ra = rq_q.partner; deg_ra = rq_q.partner; dsum_ra = lab_rd_q;
      end
      cmmg_pkg::S_PARTNER: begin
        cv_d = lab_rd_q; degv_d = deg_rd_q; dsum_ra = cu_q;
        if (reject) sts_d = 1'b1;
        else begin
          nbr_we = 1'b1; deg_we = 1'b1;
        end
      end
      cmmg_pkg::S_ADD_SUM_U: begin
        dsum_we = 1'b1;
        nbr_we = 1'b1; nbr_wa = {rq_q.partner, degv_q[SW-1:0]}; nbr_wd = rq_q.node;
        deg_we = 1'b1; deg_wa = rq_q.partner; deg_wd = degv_q + DW'(1);
      end
      cmmg_pkg::S_ADD_RD_V: dsum_ra = cv_q;
      cmmg_pkg::S_ADD_SUM_V: begin
        dsum_we = 1'b1; dsum_wa = cv_q; iedg_ra = cu_q;
      end
      cmmg_pkg::S_ADD_EDGE: begin
        iedg_we = (cu_q == cv_q);
        edge_d = edge_q + EW'(1);
      end
      cmmg_pkg::S_OLD_SUM: dold_d = dsum_rd_q;
      cmmg_pkg::S_NEW_SUM: begin
        dnew_d = dsum_rd_q; ko_d = '0; kn_d = '0; idx_d = '0;
        nbr_ra = {rq_q.node, {SW{1'b0}}};
      end
      cmmg_pkg::S_NBR: lab_ra = nbr_rd_q;
      cmmg_pkg::S_LABEL: begin
        if (lab_rd_q == cu_q) ko_d = ko_q + DW'(1);
        else if (lab_rd_q == rq_q.target) kn_d = kn_q + DW'(1);
        idx_d  = nxt;
        nbr_ra = {rq_q.node, nxt[SW-1:0]};
      end
      cmmg_pkg::S_MUL: begin
        p1_d = m_s * (kn_s - ko_s);
        p2_d = deg_s * (dold_s - dnew_s - deg_s);
      end
      cmmg_pkg::S_SUM: begin
        app_d = apply;
        if (sum > cmmg_pkg::GAIN_MAX) gain_d = cmmg_pkg::GAIN_MAX[cmmg_pkg::GAIN_W-1:0];
        else if (sum < cmmg_pkg::GAIN_MIN) gain_d = cmmg_pkg::GAIN_MIN[cmmg_pkg::GAIN_W-1:0];
        else gain_d = sum[cmmg_pkg::GAIN_W-1:0];
      end
      cmmg_pkg::S_UPD_OLD: begin
        dsum_we = 1'b1; dsum_wd = dold_q - CW'(degu_q);
        lab_we = 1'b1; iedg_ra = cu_q;
      end
      cmmg_pkg::S_UPD_NEW: begin
        dsum_we = 1'b1; dsum_wa = rq_q.target; dsum_wd = dnew_q + CW'(degu_q);
        iedg_we = 1'b1; iedg_wd = iedg_rd_q - EW'(ko_q);
      end
      cmmg_pkg::S_UPD_EDGE: begin
        iedg_we = 1'b1; iedg_wa = rq_q.target; iedg_wd = iedg_rd_q + EW'(kn_q);
      end
      cmmg_pkg::S_OUT: res_push_o = !res_full_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    rq_q <= rq_d; cu_q <= cu_d; cv_q <= cv_d; degu_q <= degu_d; degv_q <= degv_d;
    ko_q <= ko_d; kn_q <= kn_d; idx_q <= idx_d; dold_q <= dold_d; dnew_q <= dnew_d;
    p1_q <= p1_d; p2_q <= p2_d; gain_q <= gain_d; app_q <= app_d; sts_q <= sts_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= cmmg_pkg::S_CLEAR;
      clr_q  <= '0;
      edge_q <= '0;
    end else begin
      st_q   <= st_d;
      clr_q  <= clr_d;
      edge_q <= edge_d;
    end
  end
endmodule
`default_nettype wire

FILE: src/community_move_modularity_gain.sv
// From queue head to result: an add edge runs the add states, while a rejected edge and a
//   node already in its target community go to FIN; move/try/query scan all deg neighbors
//   (deg = node degree, up to 32), then run the update states when applied.
// Throughput: one request at a time in the engine; the next starts the cycle after the
//   result is pushed. The neighbor scan (one slot read and one label read per neighbor)
//   sets the rate; a full result queue stalls the engine. Reset: asynchronous, active low;
//   then a clearing pass over the label, degree and community memories, holding full_o high.
`default_nettype none
module community_move_modularity_gain (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         push,
  output logic                        full,
  input  wire  [1:0]                  operation_i,
  input  wire  [cmmg_pkg::NODE_W-1:0] node_i,
  input  wire  [cmmg_pkg::NODE_W-1:0] partner_node_i,
  input  wire  [cmmg_pkg::NODE_W-1:0] target_community_i,
  output logic                        empty,
  input  wire                         pop,
  output logic signed [cmmg_pkg::GAIN_W-1:0] gain_o,
  output logic                        applied_o,
  output logic                        status_o,
  output logic [cmmg_pkg::NODE_W-1:0] current_community_o,
  output logic [cmmg_pkg::DSUM_W-1:0] community_degree_o,
  output logic [cmmg_pkg::EDGE_W-1:0] community_edges_o
);
  // front: request queue; back: engine; results leave through a second queue
  cmmg_pkg::eng_stat_t stat;
  cmmg_pkg::req_t      req;
  cmmg_pkg::res_t      res_in, res_out;
  logic                req_valid, res_push, res_full;

  cmmg_front u_front (
    .clk_i, .rst_ni, .push_i(push), .operation_i, .node_i, .partner_node_i,
    .target_community_i, .full_o(full), .stat_i(stat),
    .req_valid_o(req_valid), .req_o(req)
  );

  cmmg_engine u_engine (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_i(req), .stat_o(stat),
    .res_push_o(res_push), .res_o(res_in), .res_full_i(res_full)
  );

  cmmg_resq u_resq (
    .clk_i, .rst_ni, .push_i(res_push), .res_i(res_in), .full_o(res_full),
    .pop_i(pop), .empty_o(empty), .res_o(res_out)
  );

  assign gain_o              = res_out.gain;
  assign applied_o           = res_out.applied;
  assign status_o            = res_out.status;
  assign current_community_o = res_out.cur;
  assign community_degree_o  = res_out.cdeg;
  assign community_edges_o   = res_out.cedges;

  // no request enters while the memories are being cleared
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.clearing |-> full) else $error("request accepted during clearing");

  // the engine never pushes into a full result queue
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result queue overrun");

  // a rejected edge never reports a label change
  a_reject_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !(res_in.applied && res_in.status)) else $error("applied with reject");
endmodule
`default_nettype wire
